/* rtl/core/cubic_curve_point_eval_assert.svh */
// Assertion macros for the curve evaluator checker.
`ifndef CUBIC_CURVE_POINT_EVAL_ASSERT_SVH
`define CUBIC_CURVE_POINT_EVAL_ASSERT_SVH

// Same-cycle implication, off while reset is low.
`define CCPE_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("cubic curve evaluator: same-cycle check failed");

// Next-cycle implication, off while reset is low.
`define CCPE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("cubic curve evaluator: next-cycle check failed");

// Next-cycle implication that also runs through reset.
`define CCPE_ASSERT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("cubic curve evaluator: reset check failed");

`endif

/* rtl/core/ccpe_pkg.sv */
// Shared constants and types for the cubic curve point evaluator.
package ccpe_pkg;

    localparam int MAX_POINTS    = 16;
    localparam int COORD_W       = 32;
    localparam int POS_FRAC_BITS = 16;

    localparam int IDX_W    = $clog2(MAX_POINTS);
    localparam int POS_W    = POS_FRAC_BITS + 1;
    localparam int CNT_W    = 5;
    localparam int PIDX_W   = 4;
    localparam int APB_DW   = 32;
    localparam int PADDR_W  = 2;

    localparam logic [CNT_W-1:0]   POINT_COUNT_RESET = CNT_W'(4);
    localparam logic [PADDR_W-1:0] ADDR_POINT_COUNT  = PADDR_W'(0);

    // input word kinds
    typedef enum logic {
        REQ_WRITE = 1'b0,
        REQ_EVAL  = 1'b1
    } req_t;

    typedef logic signed [COORD_W-1:0]   coord_t;
    typedef logic [POS_FRAC_BITS-1:0]    frac_t;

    localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    // load enables for the per-axis arithmetic stages
    typedef struct packed {
        logic diff;
        logic mul1;
        logic add1;
        logic mul2;
        logic add2;
        logic mul3;
        logic fin;
    } stage_en_t;

endpackage

/* rtl/core/ccpe_axis.sv */
// One axis of the cubic datapath: differences, three Horner steps, saturation.
module ccpe_axis
    import ccpe_pkg::*;
(
    input  logic      aclk,
    input  stage_en_t en,
    input  coord_t    p0,
    input  coord_t    p1,
    input  coord_t    p2,
    input  coord_t    p3,
    input  frac_t     t_mul1,
    input  frac_t     t_mul2,
    input  frac_t     t_mul3,
    output coord_t    result,
    output logic      clip
);

    localparam int D_W    = COORD_W + 1;
    localparam int P_W    = COORD_W + 2;
    localparam int Q_W    = COORD_W + 3;
    localparam int V_W    = COORD_W + 4;
    localparam int PROD_W = V_W + POS_FRAC_BITS + 1;

    typedef logic signed [V_W-1:0]    wide_t;
    typedef logic signed [PROD_W-1:0] prod_t;

    localparam prod_t RND_HALF = prod_t'({1'b1, {(POS_FRAC_BITS-1){1'b0}}});

    function automatic prod_t mul_frac(wide_t a, frac_t t);
        return PROD_W'(a) * PROD_W'($signed({1'b0, t}));
    endfunction

    // x*t/2^k rounded to nearest, ties up, plus the next coefficient
    function automatic wide_t round_add(prod_t pr, wide_t term);
        prod_t sh;
        sh = (pr + RND_HALF) >>> POS_FRAC_BITS;
        return V_W'(sh) + term;
    endfunction

    logic signed [D_W-1:0] d01, d32, r_c;
    logic signed [P_W-1:0] p_c;
    logic signed [Q_W-1:0] q_c;

    logic signed [P_W-1:0] p_reg;
    logic signed [Q_W-1:0] q_reg, q4_reg;
    logic signed [D_W-1:0] r_reg, r4_reg, r5_reg, r6_reg;
    coord_t                s_reg, s4_reg, s5_reg, s6_reg, s7_reg, s8_reg;
    prod_t                 prod1_reg, prod2_reg, prod3_reg;
    wide_t                 v1_reg, v2_reg, v3;
    coord_t                result_reg;
    logic                  clip_reg;

    always_comb begin
        d01 = D_W'(p0) - D_W'(p1);
        d32 = D_W'(p3) - D_W'(p2);
        p_c = P_W'(d32) - P_W'(d01);
        q_c = Q_W'(d01) - Q_W'(p_c);
        r_c = D_W'(p2) - D_W'(p0);
    end

    assign v3 = round_add(prod3_reg, V_W'(s8_reg));

    always_ff @(posedge aclk) begin
        if (en.diff) begin
            p_reg <= p_c;
            q_reg <= q_c;
            r_reg <= r_c;
            s_reg <= p1;
        end
        if (en.mul1) begin
            prod1_reg <= mul_frac(V_W'(p_reg), t_mul1);
            q4_reg    <= q_reg;
            r4_reg    <= r_reg;
            s4_reg    <= s_reg;
        end
        if (en.add1) begin
            v1_reg <= round_add(prod1_reg, V_W'(q4_reg));
            r5_reg <= r4_reg;
            s5_reg <= s4_reg;
        end
        if (en.mul2) begin
            prod2_reg <= mul_frac(v1_reg, t_mul2);
            r6_reg    <= r5_reg;
            s6_reg    <= s5_reg;
        end
        if (en.add2) begin
            v2_reg <= round_add(prod2_reg, V_W'(r6_reg));
            s7_reg <= s6_reg;
        end
        if (en.mul3) begin
            prod3_reg <= mul_frac(v2_reg, t_mul3);
            s8_reg    <= s7_reg;
        end
        if (en.fin) begin
            priority if (v3 > V_W'(COORD_MAX)) begin
                result_reg <= COORD_MAX;
                clip_reg   <= 1'b1;
            end else if (v3 < V_W'(COORD_MIN)) begin
                result_reg <= COORD_MIN;
                clip_reg   <= 1'b1;
            end else begin
                result_reg <= COORD_W'(v3);
                clip_reg   <= 1'b0;
            end
        end
    end

    assign result = result_reg;
    assign clip   = clip_reg;

endmodule

/* rtl/core/cubic_curve_point_eval.sv */
// Top level of the cubic curve point evaluator: table, index stage, pipeline control.
// Usage:
//   One input channel (s_*) carries two kinds of word. A write word (req_type 0)
//   stores point_x/y/z at table entry point_index on the edge it is accepted and
//   gives no result. An evaluate word (req_type 1) carries param_pos in Q1.16
//   and gives one result word on the m_* channel: the four-point cubic through
//   the neighboring control points, per axis, in Q16.16, with m_clipped set when
//   any axis saturated. point_count is an APB register at byte address 0
//   (reset 4); change it only while no evaluate word is in flight.
// Stages and throughput:
//   Nine register stages: index split, table read, differences, then three
//   multiply/round-add pairs of a Horner evaluation, the last ending in the
//   output register. One word per clock is accepted and delivered sustained while
//   m_ready stays high. The table is two copies of a 16-entry array with two
//   read ports each.
// Reset and backpressure:
//   aresetn (synchronous, low) clears all stage valids and sets point_count to 4;
//   the table keeps whatever it held and must be written before use. Each stage
//   holds while the next is full and stalled, so bubbles close up and s_ready
//   stays high as long as any stage has room.
module cubic_curve_point_eval
    import ccpe_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_req_type,
    input  logic [PIDX_W-1:0]    s_point_index,
    input  coord_t               s_point_x,
    input  coord_t               s_point_y,
    input  coord_t               s_point_z,
    input  logic [POS_W-1:0]     s_param_pos,

    output logic                 m_valid,
    input  logic                 m_ready,
    output coord_t               m_curve_x,
    output coord_t               m_curve_y,
    output coord_t               m_curve_z,
    output logic                 m_clipped,

    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [APB_DW-1:0]    pwdata,
    output logic [APB_DW-1:0]    prdata,
    output logic                 pready
);

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } point_t;

    // stage numbering
    localparam int ST_IDX  = 1;
    localparam int ST_MEM  = 2;
    localparam int ST_DIFF = 3;
    localparam int ST_MUL1 = 4;
    localparam int ST_ADD1 = 5;
    localparam int ST_MUL2 = 6;
    localparam int ST_ADD2 = 7;
    localparam int ST_MUL3 = 8;
    localparam int ST_FIN  = 9;
    localparam int NSTG    = ST_FIN;

    localparam int CMP_W = (IDX_W + 1 > CNT_W) ? IDX_W + 1 : CNT_W;
    localparam int SCL_W = POS_FRAC_BITS + IDX_W;

    // ---------------- configuration ----------------
    logic [CNT_W-1:0] point_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            point_count_reg <= POINT_COUNT_RESET;
        end else if (psel && penable && pwrite && pready && paddr == ADDR_POINT_COUNT) begin
            point_count_reg <= pwdata[CNT_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_POINT_COUNT) ? APB_DW'(point_count_reg) : '0;

    // ---------------- pipeline control ----------------
    logic [NSTG:1] vld_reg;
    logic [NSTG:1] rdy;
    logic          is_eval, is_write, wr_en;

    // a stage can load when it is empty or its own word moves on
    always_comb begin
        rdy[NSTG] = !vld_reg[NSTG] || m_ready;
        for (int k = NSTG - 1; k >= 1; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign s_ready  = rdy[ST_IDX];
    assign is_eval  = (s_req_type == REQ_EVAL);
    assign is_write = (s_req_type == REQ_WRITE);
    // writes never enter the pipe; out-of-range indexes are dropped
    assign wr_en    = s_valid && s_ready && is_write && (int'(s_point_index) < MAX_POINTS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (rdy[ST_IDX]) begin
                vld_reg[ST_IDX] <= s_valid && is_eval;
            end
            for (int k = ST_IDX + 1; k <= NSTG; k++) begin
                if (rdy[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // ---------------- stage 1: segment index and fraction ----------------
    logic [CMP_W-1:0] pc_ext, pc_clamp;
    logic [IDX_W-1:0] n_last, i0_c, i1_c, i2_c, i3_c;
    logic [SCL_W-1:0] scaled;
    frac_t            t_c;

    always_comb begin
        pc_ext = CMP_W'(point_count_reg);
        priority if (pc_ext < CMP_W'(2)) begin
            pc_clamp = CMP_W'(2);
        end else if (pc_ext > CMP_W'(MAX_POINTS)) begin
            pc_clamp = CMP_W'(MAX_POINTS);
        end else begin
            pc_clamp = pc_ext;
        end
        n_last = IDX_W'(pc_clamp - CMP_W'(1));
        scaled = SCL_W'(s_param_pos[POS_FRAC_BITS-1:0]) * SCL_W'(n_last);

        priority if (s_param_pos == '0) begin
            i1_c = '0;
            i2_c = '0;
            t_c  = '0;
        end else if (s_param_pos[POS_FRAC_BITS]) begin
            // position one or above: last point in use
            i1_c = n_last;
            i2_c = n_last;
            t_c  = '0;
        end else begin
            i1_c = scaled[SCL_W-1:POS_FRAC_BITS];
            t_c  = scaled[POS_FRAC_BITS-1:0];
            i2_c = (i1_c == n_last) ? n_last : i1_c + IDX_W'(1);
        end
        i0_c = (i1_c == '0) ? '0 : i1_c - IDX_W'(1);
        i3_c = (i2_c == n_last) ? n_last : i2_c + IDX_W'(1);
    end

    logic [IDX_W-1:0] i0_reg, i1_reg, i2_reg, i3_reg;
    frac_t            t_reg [ST_IDX:ST_MUL3-1];

    always_ff @(posedge aclk) begin
        if (rdy[ST_IDX]) begin
            i0_reg        <= i0_c;
            i1_reg        <= i1_c;
            i2_reg        <= i2_c;
            i3_reg        <= i3_c;
            t_reg[ST_IDX] <= t_c;
        end
        for (int k = ST_IDX + 1; k <= ST_MUL3 - 1; k++) begin
            if (rdy[k]) begin
                t_reg[k] <= t_reg[k-1];
            end
        end
    end

    // ---------------- stage 2: table read ----------------
    // copy A serves the two lower neighbors, copy B the two upper ones
    point_t mem_a [MAX_POINTS];
    point_t mem_b [MAX_POINTS];
    point_t pnt0_reg, pnt1_reg, pnt2_reg, pnt3_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_a[IDX_W'(s_point_index)] <= '{x: s_point_x, y: s_point_y, z: s_point_z};
            mem_b[IDX_W'(s_point_index)] <= '{x: s_point_x, y: s_point_y, z: s_point_z};
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[ST_MEM]) begin
            pnt0_reg <= mem_a[i0_reg];
            pnt1_reg <= mem_a[i1_reg];
            pnt2_reg <= mem_b[i2_reg];
            pnt3_reg <= mem_b[i3_reg];
        end
    end

    // ---------------- stages 3..9: per-axis arithmetic ----------------
    stage_en_t axis_en;
    logic      clip_x, clip_y, clip_z;

    always_comb begin
        axis_en.diff = rdy[ST_DIFF];
        axis_en.mul1 = rdy[ST_MUL1];
        axis_en.add1 = rdy[ST_ADD1];
        axis_en.mul2 = rdy[ST_MUL2];
        axis_en.add2 = rdy[ST_ADD2];
        axis_en.mul3 = rdy[ST_MUL3];
        axis_en.fin  = rdy[ST_FIN];
    end

    ccpe_axis u_axis_x (
        .aclk   (aclk),
        .en     (axis_en),
        .p0     (pnt0_reg.x),
        .p1     (pnt1_reg.x),
        .p2     (pnt2_reg.x),
        .p3     (pnt3_reg.x),
        .t_mul1 (t_reg[ST_DIFF]),
        .t_mul2 (t_reg[ST_ADD1]),
        .t_mul3 (t_reg[ST_ADD2]),
        .result (m_curve_x),
        .clip   (clip_x)
    );

    ccpe_axis u_axis_y (
        .aclk   (aclk),
        .en     (axis_en),
        .p0     (pnt0_reg.y),
        .p1     (pnt1_reg.y),
        .p2     (pnt2_reg.y),
        .p3     (pnt3_reg.y),
        .t_mul1 (t_reg[ST_DIFF]),
        .t_mul2 (t_reg[ST_ADD1]),
        .t_mul3 (t_reg[ST_ADD2]),
        .result (m_curve_y),
        .clip   (clip_y)
    );

    ccpe_axis u_axis_z (
        .aclk   (aclk),
        .en     (axis_en),
        .p0     (pnt0_reg.z),
        .p1     (pnt1_reg.z),
        .p2     (pnt2_reg.z),
        .p3     (pnt3_reg.z),
        .t_mul1 (t_reg[ST_DIFF]),
        .t_mul2 (t_reg[ST_ADD1]),
        .t_mul3 (t_reg[ST_ADD2]),
        .result (m_curve_z),
        .clip   (clip_z)
    );

    assign m_valid   = vld_reg[NSTG];
    assign m_clipped = clip_x | clip_y | clip_z;

endmodule

/* rtl/core/ccpe_checker.sv */
// Port-level checks for the cubic curve point evaluator, bound to the top level.
`include "cubic_curve_point_eval_assert.svh"

module ccpe_checker
    import ccpe_pkg::*;
(
    input logic   aclk,
    input logic   aresetn,
    input logic   s_ready,
    input logic   m_valid,
    input logic   m_ready,
    input coord_t m_curve_x,
    input coord_t m_curve_y,
    input coord_t m_curve_z,
    input logic   m_clipped
);

    logic [3*COORD_W:0] out_word;
    logic               rail_hit;

    assign out_word = {m_curve_x, m_curve_y, m_curve_z, m_clipped};
    assign rail_hit = (m_curve_x == COORD_MAX) || (m_curve_x == COORD_MIN) ||
                      (m_curve_y == COORD_MAX) || (m_curve_y == COORD_MIN) ||
                      (m_curve_z == COORD_MAX) || (m_curve_z == COORD_MIN);

    // a stalled result word holds
    `CCPE_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(out_word))

    // a clipped word has at least one axis at a rail
    `CCPE_ASSERT_NOW(a_clip_rail, aclk, aresetn, m_valid && m_clipped, rail_hit)

    // with the sink ready the whole pipe moves, so the source is never held off
    `CCPE_ASSERT_NOW(a_ready_flow, aclk, aresetn, m_ready, s_ready)

    // reset empties the pipe
    `CCPE_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_valid)

endmodule

bind cubic_curve_point_eval ccpe_checker u_ccpe_checker (.*);

/* bench/cubic_curve_point_eval_tb.sv */
// Self-checking testbench for the cubic curve point evaluator, with its scoreboard class.
`timescale 1ns / 100ps

import ccpe_pkg::*;

// One word on the input channel.
typedef struct {
    logic               kind;
    logic [PIDX_W-1:0]  index;
    coord_t             x;
    coord_t             y;
    coord_t             z;
    logic [POS_W-1:0]   pos;
} curve_word_t;

// One word on the result channel.
typedef struct {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   clipped;
} curve_point_t;

// Shadow copy of the point table and point_count, plus the queue of curve points still owed.
class curve_point_scoreboard;
    coord_t             pts_x [MAX_POINTS];
    coord_t             pts_y [MAX_POINTS];
    coord_t             pts_z [MAX_POINTS];
    logic [CNT_W-1:0]   point_count;
    curve_point_t       expected_points [$];
    int                 errors;
    int                 results_seen;
    int                 evals_seen;
    int                 writes_seen;

    function new();
        point_count  = POINT_COUNT_RESET;
        errors       = 0;
        results_seen = 0;
        evals_seen   = 0;
        writes_seen  = 0;
    endfunction

    // point_count as the datapath sees it: below 2 acts as 2, above the table as the table
    function int active_points();
        int pc;
        pc = point_count;
        if (pc < 2) pc = 2;
        if (pc > MAX_POINTS) pc = MAX_POINTS;
        return pc;
    endfunction

    task report(string msg);
        errors++;
        $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    // v*t / 2^16, nearest, ties toward +inf; arithmetic shift is a floor
    function longint scale_round(longint v, longint t);
        return (v * t + (longint'(1) <<< (POS_FRAC_BITS - 1))) >>> POS_FRAC_BITS;
    endfunction

    function longint horner_axis(longint p0, longint p1, longint p2, longint p3,
                                 longint t, inout logic clip);
        longint d01, cp, cq, cr, acc;
        d01 = p0 - p1;
        cp  = (p3 - p2) - d01;
        cq  = d01 - cp;
        cr  = p2 - p0;
        acc = scale_round(cp, t) + cq;
        acc = scale_round(acc, t) + cr;
        acc = scale_round(acc, t) + p1;
        if (acc > longint'(COORD_MAX)) begin
            clip = 1'b1;
            acc  = longint'(COORD_MAX);
        end else if (acc < longint'(COORD_MIN)) begin
            clip = 1'b1;
            acc  = longint'(COORD_MIN);
        end
        return acc;
    endfunction

    function curve_point_t eval_curve_point(logic [POS_W-1:0] pos);
        int           n, i0, i1, i2, i3;
        int unsigned  scaled;
        longint       t;
        logic         clip;
        curve_point_t pt;
        n = active_points() - 1;
        if (pos == 0) begin
            i1 = 0;
            i2 = 0;
            t  = 0;
        end else if (pos >= (1 << POS_FRAC_BITS)) begin
            i1 = n;
            i2 = n;
            t  = 0;
        end else begin
            scaled = pos * n;
            i1 = scaled >> POS_FRAC_BITS;
            t  = scaled & ((1 << POS_FRAC_BITS) - 1);
            i2 = (i1 + 1 > n) ? n : i1 + 1;
        end
        i0 = (i1 == 0) ? 0 : i1 - 1;
        i3 = (i2 + 1 > n) ? n : i2 + 1;
        clip = 1'b0;
        pt.x = coord_t'(horner_axis(pts_x[i0], pts_x[i1], pts_x[i2], pts_x[i3], t, clip));
        pt.y = coord_t'(horner_axis(pts_y[i0], pts_y[i1], pts_y[i2], pts_y[i3], t, clip));
        pt.z = coord_t'(horner_axis(pts_z[i0], pts_z[i1], pts_z[i2], pts_z[i3], t, clip));
        pt.clipped = clip;
        return pt;
    endfunction

    function void note_word(curve_word_t w);
        if (w.kind == REQ_WRITE) begin
            pts_x[w.index] = w.x;
            pts_y[w.index] = w.y;
            pts_z[w.index] = w.z;
            writes_seen++;
        end else begin
            expected_points.insert(expected_points.size(), eval_curve_point(w.pos));
            evals_seen++;
        end
    endfunction

    task check_point(curve_point_t got);
        curve_point_t want;
        if (expected_points.size() == 0) begin
            report("result word with no evaluation pending");
            return;
        end
        want = expected_points.pop_front();
        results_seen++;
        if (got.x !== want.x)
            report($sformatf("result %0d curve_x %h, want %h", results_seen, got.x, want.x));
        if (got.y !== want.y)
            report($sformatf("result %0d curve_y %h, want %h", results_seen, got.y, want.y));
        if (got.z !== want.z)
            report($sformatf("result %0d curve_z %h, want %h", results_seen, got.z, want.z));
        if (got.clipped !== want.clipped)
            report($sformatf("result %0d clipped %b, want %b", results_seen, got.clipped,
                             want.clipped));
    endtask
endclass

module cubic_curve_point_eval_tb;

    logic                 aclk;
    logic                 aresetn;

    logic                 s_valid;
    logic                 s_ready;
    logic                 s_req_type;
    logic [PIDX_W-1:0]    s_point_index;
    coord_t               s_point_x;
    coord_t               s_point_y;
    coord_t               s_point_z;
    logic [POS_W-1:0]     s_param_pos;

    logic                 m_valid;
    logic                 m_ready;
    coord_t               m_curve_x;
    coord_t               m_curve_y;
    coord_t               m_curve_z;
    logic                 m_clipped;

    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [APB_DW-1:0]    pwdata;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    curve_point_scoreboard sb;

    // Idle odds in percent per cycle for each side, changed between phases.
    int snd_idle_pct;
    int rcv_idle_pct;
    // Set by the stimulus to ask the result sink for one long hold-off.
    int hold_request;
    // Cycles where a word was offered but s_ready was low.
    int stall_cycles;
    int settings_done;
    // Table entries written so far; evaluations never reach past these.
    bit [MAX_POINTS-1:0] loaded;

    cubic_curve_point_eval DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_point_index (s_point_index),
        .s_point_x     (s_point_x),
        .s_point_y     (s_point_y),
        .s_point_z     (s_point_z),
        .s_param_pos   (s_param_pos),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_curve_x     (m_curve_x),
        .m_curve_y     (m_curve_y),
        .m_curve_z     (m_curve_z),
        .m_clipped     (m_clipped),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Hard stop: many times the slowest correct run.
    initial begin
        #4_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Word builders
    // ------------------------------------------------------------------

    // Mostly mid-sized values so results sometimes stay in range, plus the rails and zero.
    function automatic coord_t random_coord();
        case ($urandom_range(0, 9))
            0:       return COORD_MAX;
            1:       return COORD_MIN;
            2:       return '0;
            default: return $signed($urandom) >>> $urandom_range(0, 24);
        endcase
    endfunction

    // Write word; param_pos is unused and carries noise.
    function automatic curve_word_t write_word(int idx, coord_t x, coord_t y, coord_t z);
        curve_word_t w;
        w.kind  = REQ_WRITE;
        w.index = PIDX_W'(idx);
        w.x     = x;
        w.y     = y;
        w.z     = z;
        w.pos   = POS_W'($urandom_range(0, (1 << POS_W) - 1));
        return w;
    endfunction

    // Evaluate word; index and point fields are unused and carry noise.
    function automatic curve_word_t eval_word(int pos);
        curve_word_t w;
        w.kind  = REQ_EVAL;
        w.index = PIDX_W'($urandom_range(0, MAX_POINTS - 1));
        w.x     = $urandom;
        w.y     = $urandom;
        w.z     = $urandom;
        w.pos   = POS_W'(pos);
        return w;
    endfunction

    // Random mix of writes and evaluations. An evaluation is swapped for a write to the
    // first unloaded entry while the active span still has holes, so the table is never
    // read where it was never written.
    function automatic curve_word_t random_word();
        int pc, i;
        pc = sb.active_points();
        if ($urandom_range(0, 99) < 30)
            return write_word($urandom_range(0, MAX_POINTS - 1), random_coord(),
                              random_coord(), random_coord());
        for (i = 0; i < pc; i++)
            if (!loaded[i]) return write_word(i, random_coord(), random_coord(), random_coord());
        case ($urandom_range(0, 19))
            0:       return eval_word(0);
            1:       return eval_word(1 << POS_FRAC_BITS);
            2:       return eval_word($urandom_range((1 << POS_FRAC_BITS) + 1, (1 << POS_W) - 1));
            default: return eval_word($urandom_range(1, (1 << POS_FRAC_BITS) - 1));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Drivers. Everything is driven at the falling edge and sampled at the rising edge.
    // ------------------------------------------------------------------

    // Offer one word, with random idle cycles ahead of it, and hold it until accepted.
    // Entered and left at a falling edge; valid stays high into the next word when the
    // next call does not idle.
    task automatic send_word(curve_word_t w);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_req_type    <= w.kind;
        s_point_index <= w.index;
        s_point_x     <= w.x;
        s_point_y     <= w.y;
        s_point_z     <= w.z;
        s_param_pos   <= w.pos;
        @(posedge aclk);
        while (!s_ready) begin
            stall_cycles++;
            @(posedge aclk);
        end
        sb.note_word(w);
        if (w.kind == REQ_WRITE) loaded[w.index] = 1'b1;
        @(negedge aclk);
    endtask

    // One APB transfer: setup cycle, then access until pready.
    task automatic apb_access(logic wr, logic [PADDR_W-1:0] addr, logic [APB_DW-1:0] wdata,
                              output logic [APB_DW-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        rdata = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Change point_count with the pipe empty, then read it back.
    // Write words give no result, so after the last result arrives a fixed pause
    // covers anything still in flight.
    task automatic set_point_count(logic [CNT_W-1:0] value);
        logic [APB_DW-1:0] rd;
        s_valid <= 1'b0;
        while (sb.expected_points.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        @(negedge aclk);
        apb_access(1'b1, ADDR_POINT_COUNT, APB_DW'(value), rd);
        sb.point_count = value;
        @(negedge aclk);
        apb_access(1'b0, ADDR_POINT_COUNT, '0, rd);
        if (rd !== APB_DW'(value))
            sb.report($sformatf("point_count read back %h, want %h", rd, value));
        settings_done++;
    endtask

    // ------------------------------------------------------------------
    // Result sink: random ready, or a counted hold-off when one is requested.
    // ------------------------------------------------------------------
    initial begin : result_sink
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        m_ready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (!hold_done && hold_request > 0) begin
                hold_left = hold_request;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
            end
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                sb.check_point('{m_curve_x, m_curve_y, m_curve_z, m_clipped});
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [APB_DW-1:0] rd;
        int                count_plan [9];
        int                seg;

        sb = new();
        // point_count settings per phase: both clamp regions, both extremes, mid values
        count_plan = '{2, 16, 0, 31, 1, 17, 7, 16, 3};

        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_req_type    = REQ_WRITE;
        s_point_index = '0;
        s_point_x     = '0;
        s_point_y     = '0;
        s_point_z     = '0;
        s_param_pos   = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        snd_idle_pct  = 0;
        rcv_idle_pct  = 0;
        hold_request  = 0;
        stall_cycles  = 0;
        settings_done = 0;
        loaded        = '0;

        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // point_count must come out of reset at its documented value
        apb_access(1'b0, ADDR_POINT_COUNT, '0, rd);
        if (rd !== APB_DW'(POINT_COUNT_RESET))
            sb.report($sformatf("point_count after reset %h, want %h", rd, POINT_COUNT_RESET));

        // Directed, four points in use. x swings rail to rail so the middle segment
        // overshoots the top, y the mirror image overshoots the bottom, z stays tame.
        send_word(write_word(0, COORD_MIN, COORD_MAX, 32'sh0000_0000));
        send_word(write_word(1, COORD_MAX, COORD_MIN, 32'sh0001_0000));
        send_word(write_word(2, COORD_MAX, COORD_MIN, 32'sh0002_0000));
        send_word(write_word(3, COORD_MIN, COORD_MAX, -32'sh0001_0000));
        // entry beyond point_count: stored, not used until the count covers it
        send_word(write_word(15, COORD_MAX, COORD_MIN, 32'sh0000_0000));
        // position zero gives the first point, one and above give the last point
        send_word(eval_word(0));
        send_word(eval_word(1));
        send_word(eval_word(21845));
        send_word(eval_word(32768));
        send_word(eval_word(43691));
        send_word(eval_word(65535));
        send_word(eval_word(1 << POS_FRAC_BITS));
        send_word(eval_word((1 << POS_W) - 1));
        // overwrite the inner points and look at the middle segment again
        send_word(write_word(1, 32'sh0000_8000, -32'sh1, COORD_MAX));
        send_word(write_word(2, -32'sh5, 32'sh5555_5555, 32'sh0000_0001));
        send_word(eval_word(32768));
        send_word(eval_word(49152));

        // Random phases: sender light / receiver heavy idling, then swapped, then none.
        for (seg = 0; seg < 9; seg++) begin
            snd_idle_pct = (seg < 3) ? 15 : (seg < 6) ? 86 : 0;
            rcv_idle_pct = (seg < 3) ? 86 : (seg < 6) ? 15 : 0;
            set_point_count(CNT_W'(count_plan[seg]));
            if (seg == 6) begin
                // long receiver hold-off while words keep coming, so the pipe backs up
                hold_request = 300;
                repeat (60) send_word(random_word());
            end
            repeat (45) send_word(random_word());
        end
        s_valid <= 1'b0;

        while (sb.expected_points.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);

        $display("Covered %0d words (%0d evaluations, %0d writes) over %0d point_count values.",
                 sb.evals_seen + sb.writes_seen, sb.evals_seen, sb.writes_seen, settings_done);
        $display("Checked %0d results; input held off for %0d cycles; %0d mismatches.",
                 sb.results_seen, stall_cycles, sb.errors);
        if (sb.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/ccpe_pkg.sv
rtl/core/ccpe_axis.sv
rtl/core/cubic_curve_point_eval.sv
rtl/core/ccpe_checker.sv
bench/cubic_curve_point_eval_tb.sv
